// ===== sv/frame_parser_crc16_check_defines.svh =====
// Assertion macros for the frame parser with CRC-16 check.
// No dependencies; included by the top level only.
`ifndef FRAME_PARSER_CRC16_CHECK_DEFINES_SVH
`define FRAME_PARSER_CRC16_CHECK_DEFINES_SVH

// Same-cycle implication, gated by the active-low reset.
`define FPC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated by the active-low reset.
`define FPC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fpc16_pkg.sv =====
// Package for the frame parser with CRC-16 check: constants, result type, CRC byte update.
// No dependencies.
package fpc16_pkg;

    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_MAGIC_FIRST  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC_SECOND = 1'd1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [8:0] POS_MAX   = 9'd511;
    localparam logic [9:0] MIN_FRAME = 10'd6;
    localparam logic [8:0] HDR_LEN   = 9'd4;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
    localparam logic [2:0] ST_LEN_ERR   = 3'd3;
    localparam logic [2:0] ST_CRC_ERR   = 3'd4;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [7:0] index;
        logic [7:0] command;
        logic [7:0] length;
        logic [2:0] status;
    } result_t;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0] data_in);
        logic [15:0] c;
        c = crc_in ^ {data_in, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/frame_parser_crc16_check.sv =====
// Top level of the frame parser with CRC-16 check.
// Depends on fpc16_pkg and frame_parser_crc16_check_defines.svh.
//
// Receives a frame one byte per beat: magic0, magic1, command, length,
// payload (length bytes) and a big-endian CRC-16/CCITT-FALSE (poly 0x1021,
// init 0xFFFF, no reflection, no final xor) over header and payload. Each
// payload byte comes out as a payload beat with its index; the beat flagged
// s_last_byte instead produces one verdict beat carrying command, length and
// status (0 ok, 1 too short, 2 bad magic, 3 length mismatch, 4 CRC mismatch,
// checked in that order). Header, CRC and surplus bytes produce no beat.
// Throughput is one byte per clock: the byte-wide CRC update and the frame
// checks sit between the frame state registers and the result register, so
// every input beat is taken in the cycle it arrives unless the result side
// is backed up. The result side has an output register plus one skid entry;
// s_ready drops only while the skid entry is occupied. Each result beat is
// registered in the output register or, while that is held, the skid entry.
// Magic registers are written through cfg_we/cfg_index/cfg_wdata and must
// only change between frames while no result is pending.
`include "frame_parser_crc16_check_defines.svh"

module frame_parser_crc16_check (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [fpc16_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fpc16_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input byte stream
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_data_byte,
    input  logic                              s_last_byte,
    // result stream
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_result_kind,
    output logic [7:0]                        m_data_out,
    output logic [7:0]                        m_payload_index,
    output logic [7:0]                        m_command_byte,
    output logic [7:0]                        m_payload_length,
    output logic [2:0]                        m_status
);
    import fpc16_pkg::*;

    // configuration
    logic [7:0]  magic0_reg;
    logic [7:0]  magic1_reg;

    // frame state
    logic [8:0]  pos_reg,  pos_next;
    logic [15:0] crc_reg,  crc_next;   // CRC over all but the two newest bytes
    logic [15:0] rx_reg,   rx_next;    // two newest bytes, newest low
    logic [7:0]  len_reg,  len_next;
    logic [7:0]  cmd_reg,  cmd_next;
    logic        mm_reg,   mm_next;

    // result path
    result_t     out_reg;
    logic        out_valid_reg;
    result_t     skid_reg;
    logic        skid_valid_reg;

    logic        accept;
    logic        take;
    logic        push;

    // per-beat intermediate values
    logic        mm_upd;
    logic [7:0]  len_upd;
    logic [7:0]  cmd_upd;
    logic [15:0] crc_upd;
    logic [15:0] rx_upd;
    logic [9:0]  total;
    logic [8:0]  pay_off;
    logic        in_payload;
    logic [2:0]  verdict_st;
    result_t     res;
    logic        res_valid;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign take    = out_valid_reg && m_ready;
    assign push    = accept && res_valid;

    // ---------------------------------------------------------------
    // Configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic0_reg <= '0;
            magic1_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MAGIC_FIRST:  magic0_reg <= cfg_wdata;
                REG_MAGIC_SECOND: magic1_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Per-byte frame logic
    // ---------------------------------------------------------------
    always_comb begin
        // header capture and magic compare
        mm_upd  = mm_reg
                  | ((pos_reg == 9'd0) && (s_data_byte != magic0_reg))
                  | ((pos_reg == 9'd1) && (s_data_byte != magic1_reg));
        cmd_upd = (pos_reg == 9'd2) ? s_data_byte : cmd_reg;
        len_upd = (pos_reg == 9'd3) ? s_data_byte : len_reg;

        // two-byte delay: the byte two places back enters the CRC, so the
        // trailing CRC field is never fed and sits in rx at frame end
        crc_upd = (pos_reg >= 9'd2) ? crc_feed(crc_reg, rx_reg[15:8]) : crc_reg;
        rx_upd  = {rx_reg[7:0], s_data_byte};

        total      = {1'b0, pos_reg} + 10'd1;
        pay_off    = pos_reg - HDR_LEN;
        in_payload = (pos_reg >= HDR_LEN) && (pay_off < {1'b0, len_upd});

        if (total < MIN_FRAME) begin
            verdict_st = ST_SHORT;
        end else if (mm_upd) begin
            verdict_st = ST_BAD_MAGIC;
        end else if (total != ({2'b00, len_upd} + MIN_FRAME)) begin
            verdict_st = ST_LEN_ERR;
        end else if (crc_upd != rx_upd) begin
            verdict_st = ST_CRC_ERR;
        end else begin
            verdict_st = ST_OK;
        end

        // result beat; unused fields are zero
        res = '0;
        if (s_last_byte) begin
            res.kind    = KIND_VERDICT;
            res.command = cmd_upd;
            res.length  = len_upd;
            res.status  = verdict_st;
        end else begin
            res.kind  = KIND_PAYLOAD;
            res.data  = s_data_byte;
            res.index = pay_off[7:0];
        end
        // last byte inside the payload gives only the verdict
        res_valid = s_last_byte || in_payload;

        // next frame state
        pos_next = pos_reg;
        crc_next = crc_reg;
        rx_next  = rx_reg;
        len_next = len_reg;
        cmd_next = cmd_reg;
        mm_next  = mm_reg;
        if (accept) begin
            if (s_last_byte) begin
                pos_next = '0;
                crc_next = CRC_INIT;
                rx_next  = '0;
                len_next = '0;
                cmd_next = '0;
                mm_next  = 1'b0;
            end else begin
                // counter saturates so overlong frames end in a length error
                pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 9'd1;
                crc_next = crc_upd;
                rx_next  = rx_upd;
                len_next = len_upd;
                cmd_next = cmd_upd;
                mm_next  = mm_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            crc_reg <= CRC_INIT;
            rx_reg  <= '0;
            len_reg <= '0;
            cmd_reg <= '0;
            mm_reg  <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            rx_reg  <= rx_next;
            len_reg <= len_next;
            cmd_reg <= cmd_next;
            mm_reg  <= mm_next;
        end
    end

    // ---------------------------------------------------------------
    // Output register with one skid entry. A new result goes to the
    // output register when it is free or being drained, else to skid.
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || take) begin
                if (skid_valid_reg) begin
                    out_reg        <= skid_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= push;
                    if (push) begin
                        out_reg <= res;
                    end
                end
            end else if (push) begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_result_kind    = out_reg.kind;
    assign m_data_out       = out_reg.data;
    assign m_payload_index  = out_reg.index;
    assign m_command_byte   = out_reg.command;
    assign m_payload_length = out_reg.length;
    assign m_status         = out_reg.status;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `FPC_ASSERT_NOW(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg,
        "skid entry occupied while output register empty")
    `FPC_ASSERT_NEXT(a_frame_cleared, aclk, aresetn, accept && s_last_byte,
        (pos_reg == 9'd0) && (crc_reg == CRC_INIT) && !mm_reg,
        "frame state not cleared after last byte")
    `FPC_ASSERT_NEXT(a_pos_saturates, aclk, aresetn,
        accept && !s_last_byte && (pos_reg == POS_MAX), pos_reg == POS_MAX,
        "byte counter wrapped")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for frame_parser_crc16_check: framed byte stream with a CRC-16 verdict.
// Depends on fpc16_pkg and the RTL; a scoreboard class predicts every result beat.

typedef logic [7:0] byte_q_t[$];

// CRC-16/CCITT-FALSE update, one bit at a time, MSB first
function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ d[i];
        c  = {c[14:0], 1'b0};
        if (fb) begin
            c = c ^ fpc16_pkg::CRC_POLY;
        end
    end
    return c;
endfunction

// Frame parser predictor plus the queue of result beats it expects.
class frame_predictor;
    localparam int MAX_REPORTS = 30;

    logic [7:0]  magic_first;
    logic [7:0]  magic_second;
    logic [8:0]  byte_pos;
    logic [15:0] crc_acc;      // CRC over all but the two newest bytes
    logic [15:0] tail;         // two newest bytes, newest low
    logic [7:0]  len_field;
    logic [7:0]  cmd_field;
    logic        magic_bad;

    fpc16_pkg::result_t expected_beats[$];
    int n_bytes;
    int n_checked;
    int n_errors;
    int verdicts[5];

    function new();
        magic_first  = '0;
        magic_second = '0;
        clear_frame();
    endfunction

    function void clear_frame();
        byte_pos  = '0;
        crc_acc   = fpc16_pkg::CRC_INIT;
        tail      = '0;
        len_field = '0;
        cmd_field = '0;
        magic_bad = 1'b0;
    endfunction

    function void set_reg(logic [fpc16_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
        case (idx)
            fpc16_pkg::REG_MAGIC_FIRST:  magic_first = val;
            fpc16_pkg::REG_MAGIC_SECOND: magic_second = val;
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_beats.size();
    endfunction

    // One accepted input beat; queues the result beat it causes, if any.
    function void note_byte(logic [7:0] d, logic last);
        fpc16_pkg::result_t r;
        logic [8:0]         pos;
        logic [8:0]         offs;
        logic [9:0]         total;
        r   = '0;
        pos = byte_pos;
        n_bytes++;
        if (pos == 9'd0 && d != magic_first) begin
            magic_bad = 1'b1;
        end
        if (pos == 9'd1 && d != magic_second) begin
            magic_bad = 1'b1;
        end
        if (pos == 9'd2) begin
            cmd_field = d;
        end
        if (pos == 9'd3) begin
            len_field = d;
        end
        // the byte two places back is known not to be CRC, so it enters the sum
        if (pos >= 9'd2) begin
            crc_acc = crc16_update(crc_acc, tail[15:8]);
        end
        tail = {tail[7:0], d};

        if (!last) begin
            if (byte_pos != fpc16_pkg::POS_MAX) begin
                byte_pos = byte_pos + 9'd1;
            end
            offs = pos - fpc16_pkg::HDR_LEN;
            if (pos >= fpc16_pkg::HDR_LEN && offs < {1'b0, len_field}) begin
                r.kind  = fpc16_pkg::KIND_PAYLOAD;
                r.data  = d;
                r.index = offs[7:0];
                expected_beats.push_back(r);
            end
        end else begin
            total     = {1'b0, pos} + 10'd1;
            r.kind    = fpc16_pkg::KIND_VERDICT;
            r.command = cmd_field;
            r.length  = len_field;
            if (total < fpc16_pkg::MIN_FRAME) begin
                r.status = fpc16_pkg::ST_SHORT;
            end else if (magic_bad) begin
                r.status = fpc16_pkg::ST_BAD_MAGIC;
            end else if (total != {2'b00, len_field} + fpc16_pkg::MIN_FRAME) begin
                r.status = fpc16_pkg::ST_LEN_ERR;
            end else if (crc_acc != tail) begin
                r.status = fpc16_pkg::ST_CRC_ERR;
            end else begin
                r.status = fpc16_pkg::ST_OK;
            end
            expected_beats.push_back(r);
            clear_frame();
        end
    endfunction

    task report_mismatch(string what);
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
            $display("tb_top: mismatch %0d at %0t: %s", n_errors, $time, what);
        end
    endtask

    task field_check(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("beat %0d %s got %0h want %0h",
                                      n_checked, name, got, want));
        end
    endtask

    // One accepted result beat against the oldest expectation.
    task check_beat(fpc16_pkg::result_t got);
        fpc16_pkg::result_t want;
        if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing expected, kind %0b", got.kind));
            return;
        end
        want = expected_beats.pop_front();
        n_checked++;
        field_check("kind", 8'(got.kind), 8'(want.kind));
        field_check("data_out", got.data, want.data);
        field_check("payload_index", got.index, want.index);
        field_check("command_byte", got.command, want.command);
        field_check("payload_length", got.length, want.length);
        field_check("status", 8'(got.status), 8'(want.status));
        if (want.kind == fpc16_pkg::KIND_VERDICT) begin
            verdicts[want.status]++;
        end
    endtask
endclass

module tb_top;
    import fpc16_pkg::*;

    localparam int LIMIT       = 300000;  // cycles; the slowest clean run is far below
    localparam int HOLD_CYCLES = 64;      // long receiver hold-off
    localparam int SETTLE      = 4;       // quiet cycles after the last result beat

    typedef enum {
        FR_GOOD, FR_BAD_CRC, FR_BAD_MAGIC, FR_TRUNC, FR_EXTRA, FR_SHORT, FR_NOISE
    } frame_kind_e;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data_byte;
    logic       s_last_byte;
    logic       m_valid;
    logic       m_ready;
    logic       m_result_kind;
    logic [7:0] m_data_out;
    logic [7:0] m_payload_index;
    logic [7:0] m_command_byte;
    logic [7:0] m_payload_length;
    logic [2:0] m_status;

    frame_predictor sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_req;
    int  cycle_count;
    int  n_frames;
    int  n_settings;

    frame_parser_crc16_check i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_data_out       (m_data_out),
        .m_payload_index  (m_payload_index),
        .m_command_byte   (m_command_byte),
        .m_payload_length (m_payload_length),
        .m_status         (m_status)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: random back-pressure at the falling edge. A hold-off request
    // keeps ready low for HOLD_CYCLES, counted here, so the skid fills up.
    always begin
        @(negedge aclk);
        if (hold_req) begin
            hold_req = 1'b0;
            m_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge aclk);
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result monitor: every accepted beat goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_beat('{kind: m_result_kind, data: m_data_out,
                            index: m_payload_index, command: m_command_byte,
                            length: m_payload_length, status: m_status});
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("tb_top: timeout after %0d cycles, %0d beats still expected",
                     cycle_count, sb.pending());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // All driving tasks start and end just after a falling edge.

    // One input beat; the gap before it is random, valid then holds until taken.
    task automatic send_byte(input logic [7:0] d, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= d;
        s_last_byte <= last;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sb.note_byte(d, last);
        @(negedge aclk);
    endtask

    task automatic send_frame(input byte_q_t q);
        foreach (q[i]) begin
            send_byte(q[i], i == q.size() - 1);
        end
        n_frames++;
    endtask

    // Sender pauses until every expected beat is out, then a few quiet cycles.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Only called with the block idle.
    task automatic write_magic(input logic [7:0] first, input logic [7:0] second);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAGIC_FIRST;
        cfg_wdata <= first;
        @(posedge aclk);
        sb.set_reg(REG_MAGIC_FIRST, first);
        @(negedge aclk);
        cfg_index <= REG_MAGIC_SECOND;
        cfg_wdata <= second;
        @(posedge aclk);
        sb.set_reg(REG_MAGIC_SECOND, second);
        @(negedge aclk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic byte_q_t rand_bytes(input int n);
        byte_q_t q;
        repeat (n) q.push_back(8'($urandom));
        return q;
    endfunction

    // Header, payload and big-endian CRC; flip corrupts chosen CRC bits.
    function automatic byte_q_t make_frame(input logic [7:0] m0, input logic [7:0] m1,
                                           input logic [7:0] cmd, input logic [7:0] len,
                                           input byte_q_t pay, input logic [15:0] flip);
        byte_q_t     q;
        logic [15:0] crc;
        q.push_back(m0);
        q.push_back(m1);
        q.push_back(cmd);
        q.push_back(len);
        foreach (pay[i]) q.push_back(pay[i]);
        crc = CRC_INIT;
        foreach (q[i]) crc = crc16_update(crc, q[i]);
        crc = crc ^ flip;
        q.push_back(crc[15:8]);
        q.push_back(crc[7:0]);
        return q;
    endfunction

    // Half the frames well-formed with random content; the rest broken or noise.
    task automatic send_random_frame();
        int          roll;
        int          plen;
        int          keep;
        frame_kind_e kind;
        logic [7:0]  m0;
        logic [7:0]  m1;
        logic [15:0] flip;
        byte_q_t     q;
        roll = $urandom_range(99);
        kind = roll < 50 ? FR_GOOD : roll < 60 ? FR_BAD_CRC : roll < 70 ? FR_BAD_MAGIC :
               roll < 78 ? FR_TRUNC : roll < 85 ? FR_EXTRA : roll < 92 ? FR_SHORT : FR_NOISE;
        plen = ($urandom_range(15) == 0) ? $urandom_range(64) : $urandom_range(12);
        m0   = sb.magic_first;
        m1   = sb.magic_second;
        flip = '0;
        keep = 1 << 20;
        if (kind == FR_BAD_CRC) begin
            flip = 16'(1) << $urandom_range(15);
        end
        if (kind == FR_BAD_MAGIC) begin
            if ($urandom_range(1) != 0) begin
                m0 = m0 ^ 8'($urandom_range(1, 255));
            end else begin
                m1 = m1 ^ 8'($urandom_range(1, 255));
            end
        end
        q = make_frame(m0, m1, 8'($urandom), 8'(plen), rand_bytes(plen), flip);
        case (kind)
            // last flag anywhere before the CRC end, payload included
            FR_TRUNC: keep = $urandom_range(1, q.size() - 1);
            FR_EXTRA: repeat ($urandom_range(1, 4)) q.push_back(8'($urandom));
            FR_SHORT: keep = $urandom_range(1, 5);
            FR_NOISE: q = rand_bytes($urandom_range(1, 20));
            default: ;
        endcase
        while (q.size() > keep) void'(q.pop_back());
        send_frame(q);
        if ($urandom_range(39) == 0) begin
            drain_results();
        end
    endtask

    task automatic run_phase(input int target);
        int start;
        start = sb.n_bytes;
        while (sb.n_bytes - start < target) begin
            send_random_frame();
        end
    endtask

    initial begin
        byte_q_t q;
        sb            = new();
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_data_byte   = '0;
        s_last_byte   = 1'b0;
        m_ready       = 1'b0;
        hold_req      = 1'b0;
        cycle_count   = 0;
        n_frames      = 0;
        n_settings    = 0;
        send_idle_pct = 30;
        recv_idle_pct = 30;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed frames at the reset magics (both zero).
        // Shortest valid frame: empty payload, command all ones.
        send_frame(make_frame(8'h00, 8'h00, 8'hFF, 8'h00, rand_bytes(0), 16'h0000));
        // Payload bytes at both extremes, command zero.
        q = {8'h00, 8'hFF};
        send_frame(make_frame(8'h00, 8'h00, 8'h00, 8'h02, q, 16'h0000));
        // Single-byte frame: too short wins over the wrong magic.
        q = {8'hFF};
        send_frame(q);
        // Last flag on the first payload byte of a five-byte frame: verdict only,
        // too short, with command and length as captured.
        q = make_frame(8'h00, 8'h00, 8'h5A, 8'h03, rand_bytes(3), 16'h0000);
        while (q.size() > 5) void'(q.pop_back());
        send_frame(q);
        // Wrong first magic and a bad CRC: bad magic is reported.
        send_frame(make_frame(8'h01, 8'h00, 8'h33, 8'h00, rand_bytes(0), 16'h0001));
        drain_results();

        // Phase 1: sender mostly busy, receiver mostly stalling.
        write_magic(8'hFF, 8'h00);
        send_idle_pct = 18;
        recv_idle_pct = 87;
        run_phase(50);
        drain_results();

        // Phase 2: the other way round, random magics.
        write_magic(8'($urandom), 8'($urandom));
        send_idle_pct = 87;
        recv_idle_pct = 18;
        run_phase(50);
        drain_results();

        // Phase 3: no idling; long hold-off, then the longest length field
        // in an overlong frame.
        write_magic(8'hFF, 8'hFF);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        send_frame(make_frame(8'hFF, 8'hFF, 8'($urandom), 8'd40, rand_bytes(40), 16'h0000));
        run_phase(40);
        // 514 bytes: payload indexes run up to 254, the position counter
        // saturates and a length mismatch is expected
        send_frame(make_frame(8'hFF, 8'hFF, 8'($urandom), 8'd255, rand_bytes(508), 16'h0000));
        drain_results();

        $display("tb_top: %0d bytes in %0d frames, %0d result beats checked, %0d magic settings",
                 sb.n_bytes, n_frames, sb.n_checked, n_settings + 1);
        $display("tb_top: verdicts ok %0d, short %0d, bad magic %0d, length %0d, crc %0d",
                 sb.verdicts[ST_OK], sb.verdicts[ST_SHORT], sb.verdicts[ST_BAD_MAGIC],
                 sb.verdicts[ST_LEN_ERR], sb.verdicts[ST_CRC_ERR]);
        if (sb.n_errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/fpc16_pkg.sv
sv/frame_parser_crc16_check.sv
tb/tb_top.sv
